### rtl/core/iecl_pkg.sv
// iecl_pkg: types and constants shared by the ICMP echo per-slot limiter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iecl_pkg;

  localparam int unsigned SLOT_COUNT_DEF  = 64;
  localparam int unsigned SLOT_COUNT_MAX  = 1024;
  localparam int unsigned SLOT_W          = 6;
  localparam int unsigned CNT_W           = 64;
  localparam int unsigned THR_W           = 32;
  localparam int unsigned OFF_W           = 6;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd100;

  localparam logic [OFF_W-1:0] MIN_FRAME_LEN  = 6'd42;
  localparam logic [OFF_W-1:0] POS_ETYPE_HI   = 6'd12;
  localparam logic [OFF_W-1:0] POS_ETYPE_LO   = 6'd13;
  localparam logic [OFF_W-1:0] POS_PROTO      = 6'd23;
  localparam logic [OFF_W-1:0] POS_ICMP_TYPE  = 6'd34;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;

  typedef struct packed {
    logic [7:0]        frame_byte;
    logic              frame_last;
    logic [SLOT_W-1:0] slot_id;
  } in_item_t;

  typedef struct packed {
    logic             drop;
    logic             counted;
    logic [CNT_W-1:0] count_after;
  } out_item_t;

  // Parser verdict for the byte accepted this cycle.
  typedef struct packed {
    logic last;
    logic match;
  } parse_t;

endpackage

`default_nettype wire

### rtl/core/icmp_echo_per_cpu_count_limiter.sv
// icmp_echo_per_cpu_count_limiter: per-slot ICMP echo counter and drop verdict.
// Depends on iecl_pkg, iecl_parse and iecl_ram.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------
//   in_      | input     | in_valid / in_stall | iecl_pkg::in_item_t
//   out_     | output    | out_valid/out_stall | iecl_pkg::out_item_t
//   cfg_     | input     | cfg_valid/cfg_ready | drop_threshold, 32 bits
//
// One byte is accepted per cycle while in_stall is low. A final byte reads
// its slot counter from the counter RAM, the next cycle adds one, compares and
// writes back; a one-entry bypass covers back-to-back frames on the same slot.
// The result is formed in stage 1 and leaves through a 4-entry output queue.
// After reset a clearing pass zeroes the counter RAM, with in_stall high while
// it runs. in_stall also rises when the output queue could overflow.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_per_cpu_count_limiter #(
  parameter int unsigned SLOT_COUNT = iecl_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire iecl_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output iecl_pkg::out_item_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [iecl_pkg::THR_W-1:0]  cfg_data
);

  localparam int unsigned AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CMP_W = 11;
  localparam int unsigned CNT_W = iecl_pkg::CNT_W;

  logic in_acc;
  iecl_pkg::parse_t pv;

  // threshold register
  logic [iecl_pkg::THR_W-1:0] thr_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= iecl_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  assign in_acc = in_valid && !in_stall;

  iecl_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .item    (in_data),
    .verdict (pv)
  );

  // slot decode
  logic          slot_ok;
  logic [AW-1:0] slot_addr;
  assign slot_ok   = {{(CMP_W-iecl_pkg::SLOT_W){1'b0}}, in_data.slot_id} < CMP_W'(SLOT_COUNT);
  assign slot_addr = AW'({{AW{1'b0}}, in_data.slot_id});

  // clearing pass
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(SLOT_COUNT - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // stage 1: counter read returns
  logic          s1_v_r;
  logic          s1_match_r;
  logic          s1_ok_r;
  logic [AW-1:0] s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc && pv.last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_match_r <= pv.match;
      s1_ok_r    <= slot_ok;
      s1_addr_r  <= slot_addr;
    end
  end

  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] cnt_inc;
  logic             upd;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W-1:0] mem_wdata;

  // bypass of last cycle's write, which the read issued in that cycle missed
  logic             fwd_v_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [CNT_W-1:0] fwd_data_r;

  assign base    = (fwd_v_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rd_data;
  assign cnt_inc = base + 1'b1;
  assign upd     = s1_v_r && s1_ok_r && s1_match_r;

  always_comb begin
    mem_we    = upd;
    mem_waddr = s1_addr_r;
    mem_wdata = cnt_inc;
    if (clr_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= upd && !clr_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= cnt_inc;
  end

  iecl_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SLOT_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (slot_addr),
    .rdata (rd_data)
  );

  iecl_pkg::out_item_t res;

  always_comb begin
    res.drop        = 1'b0;
    res.counted     = 1'b0;
    res.count_after = '0;
    if (s1_ok_r) begin
      if (s1_match_r) begin
        res.counted     = 1'b1;
        res.count_after = cnt_inc;
        res.drop        = cnt_inc > {{(CNT_W-iecl_pkg::THR_W){1'b0}}, thr_r};
      end else begin
        res.count_after = base;
      end
    end
  end

  // output queue
  iecl_pkg::out_item_t q_mem [4];
  logic [1:0] q_head_r, q_tail_r;
  logic [2:0] q_cnt_r;
  logic       push, pop;

  assign push      = s1_v_r;
  assign out_valid = q_cnt_r != 3'd0;
  assign out_data  = q_mem[q_head_r];
  assign pop       = out_valid && !out_stall;
  // one result may still sit in stage 1; keep room for it and the next one
  assign in_stall  = clr_r || (({1'b0, q_cnt_r} + {3'b000, s1_v_r}) > 4'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        q_tail_r <= q_tail_r + 1'b1;
      end
      if (pop) begin
        q_head_r <= q_head_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + {2'b00, push} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_tail_r] <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/iecl_ram.sv
// iecl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module iecl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/iecl_parse.sv
// iecl_parse: per-frame header capture (ethertype, IP protocol, ICMP type).
// Depends on iecl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iecl_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire iecl_pkg::in_item_t item,
  output iecl_pkg::parse_t        verdict
);

  logic [iecl_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [15:0]                etype_r, etype_nxt;
  logic [7:0]                 proto_r, proto_nxt;
  logic [7:0]                 itype_r, itype_nxt;

  always_comb begin
    etype_nxt = etype_r;
    proto_nxt = proto_r;
    itype_nxt = itype_r;
    if (off_r == iecl_pkg::POS_ETYPE_HI) begin
      etype_nxt = {item.frame_byte, 8'h00};
    end else if (off_r == iecl_pkg::POS_ETYPE_LO) begin
      etype_nxt = {etype_r[15:8], item.frame_byte};
    end else if (off_r == iecl_pkg::POS_PROTO) begin
      proto_nxt = item.frame_byte;
    end else if (off_r == iecl_pkg::POS_ICMP_TYPE) begin
      itype_nxt = item.frame_byte;
    end
    // length counter saturates once the minimum frame length is reached
    off_nxt = (off_r < iecl_pkg::MIN_FRAME_LEN) ? off_r + 1'b1 : off_r;
  end

  assign verdict.last  = item.frame_last;
  assign verdict.match = (off_nxt >= iecl_pkg::MIN_FRAME_LEN) &&
                         (etype_nxt == iecl_pkg::ETHERTYPE_IPV4) &&
                         (proto_nxt == iecl_pkg::PROTO_ICMP) &&
                         (itype_nxt == iecl_pkg::ICMP_ECHO_REQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      etype_r <= '0;
      proto_r <= '0;
      itype_r <= '0;
    end else if (accept) begin
      if (item.frame_last) begin
        off_r   <= '0;
        etype_r <= '0;
        proto_r <= '0;
        itype_r <= '0;
      end else begin
        off_r   <= off_nxt;
        etype_r <= etype_nxt;
        proto_r <= proto_nxt;
        itype_r <= itype_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### bench/echo_verdict_checker.sv
// echo_verdict_checker: watches the byte, verdict and threshold channels of the
// ICMP echo limiter, predicts each frame verdict and compares it with the block.
// Depends on iecl_pkg for the payload types.
`timescale 1ns / 1ps

module echo_verdict_checker #(
  parameter int unsigned SLOT_COUNT = iecl_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  iecl_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  iecl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending
);

  localparam logic [5:0]  OFS_ETYPE_HI  = 6'd12;
  localparam logic [5:0]  OFS_ETYPE_LO  = 6'd13;
  localparam logic [5:0]  OFS_PROTO     = 6'd23;
  localparam logic [5:0]  OFS_ICMP_TYPE = 6'd34;
  localparam logic [5:0]  SHORTEST_ECHO = 6'd42;
  localparam logic [15:0] IPV4_ETYPE    = 16'h0800;
  localparam logic [7:0]  ICMP_PROTO    = 8'd1;
  localparam logic [7:0]  ECHO_REQUEST  = 8'd8;
  localparam logic [31:0] LIMIT_AT_RESET = 32'd100;

  logic [5:0]  frame_pos;
  logic [15:0] etype_cap;
  logic [7:0]  proto_cap;
  logic [7:0]  icmp_cap;
  logic [31:0] drop_limit;
  logic [63:0] echo_tally [SLOT_COUNT];

  iecl_pkg::out_item_t due_verdicts [$];
  iecl_pkg::out_item_t want;

  task automatic tally_byte(input iecl_pkg::in_item_t b);
    iecl_pkg::out_item_t v;
    logic echo_hit;
    case (frame_pos)
      OFS_ETYPE_HI:  etype_cap = {b.frame_byte, 8'h00};
      OFS_ETYPE_LO:  etype_cap[7:0] = b.frame_byte;
      OFS_PROTO:     proto_cap = b.frame_byte;
      OFS_ICMP_TYPE: icmp_cap = b.frame_byte;
      default: ;
    endcase
    if (frame_pos < SHORTEST_ECHO) frame_pos = frame_pos + 6'd1;
    if (b.frame_last) begin
      echo_hit = (frame_pos >= SHORTEST_ECHO) && (etype_cap == IPV4_ETYPE) &&
                 (proto_cap == ICMP_PROTO) && (icmp_cap == ECHO_REQUEST);
      v = '0;
      // slots past the table pass uncounted with a zero count
      if (b.slot_id < SLOT_COUNT) begin
        v.count_after = echo_tally[b.slot_id];
        if (echo_hit) begin
          v.count_after = v.count_after + 64'd1;
          echo_tally[b.slot_id] = v.count_after;
          v.counted = 1'b1;
          v.drop = v.count_after > {32'd0, drop_limit};
        end
      end
      due_verdicts.push_back(v);
      frame_pos = '0;
      etype_cap = '0;
      proto_cap = '0;
      icmp_cap = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_pos = '0;
      etype_cap = '0;
      proto_cap = '0;
      icmp_cap = '0;
      drop_limit = LIMIT_AT_RESET;
      foreach (echo_tally[i]) echo_tally[i] = '0;
      due_verdicts.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) drop_limit = cfg_data;
      if (out_valid && !out_stall) begin
        if (due_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual drop=%0b counted=%0b count=%0d",
                   $time, out_data.drop, out_data.counted, out_data.count_after);
          errors++;
        end else begin
          want = due_verdicts.pop_front();
          if (out_data.drop !== want.drop) begin
            $display("%0t: drop expected %0b actual %0b", $time, want.drop, out_data.drop);
            errors++;
          end
          if (out_data.counted !== want.counted) begin
            $display("%0t: counted expected %0b actual %0b", $time, want.counted,
                     out_data.counted);
            errors++;
          end
          if (out_data.count_after !== want.count_after) begin
            $display("%0t: count_after expected %0d actual %0d", $time, want.count_after,
                     out_data.count_after);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) tally_byte(in_data);
    end
    pending = due_verdicts.size();
  end

endmodule

### bench/tb.sv
// tb: drives frames, threshold writes and output backpressure into the ICMP
// echo limiter and reports the verdict of the checker.
// Depends on iecl_pkg, icmp_echo_per_cpu_count_limiter and echo_verdict_checker.
`timescale 1ns / 1ps

module tb;

  typedef enum {FR_ECHO, FR_BROKEN, FR_NOISE} frame_kind_t;

  localparam int OFS_ETYPE_HI  = 12;
  localparam int OFS_ETYPE_LO  = 13;
  localparam int OFS_PROTO     = 23;
  localparam int OFS_ICMP_TYPE = 34;
  localparam int BYTE_TARGET   = 560;
  localparam int FRAME_TARGET  = 15;
  localparam int PHASES        = 6;
  localparam int HOLD_CYCLES   = 80;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  iecl_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  iecl_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [iecl_pkg::THR_W-1:0]    cfg_data = '0;

  int errors;
  int pending;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit long_hold_req = 1'b0;
  int bytes_sent = 0;
  int frames_sent = 0;
  logic [5:0] hot_slots [4] = '{6'd0, 6'd21, 6'd42, 6'd63};

  always #4 clk = ~clk;

  icmp_echo_per_cpu_count_limiter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  echo_verdict_checker verdict_watch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // All tasks below start and end on a falling edge.
  task automatic push_byte(input logic [7:0] value, input logic last, input logic [5:0] slot);
    iecl_pkg::in_item_t it;
    int gap;
    it.frame_byte = value;
    it.frame_last = last;
    it.slot_id = slot;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input frame_kind_t kind, input logic [5:0] slot,
                            input int bad_pos, input logic [7:0] bad_mask);
    logic [7:0] fb [$];
    logic [5:0] tag;
    repeat (len) fb.push_back(8'($urandom_range(0, 255)));
    if (kind != FR_NOISE) begin
      if (len > OFS_ETYPE_HI) fb[OFS_ETYPE_HI] = 8'h08;
      if (len > OFS_ETYPE_LO) fb[OFS_ETYPE_LO] = 8'h00;
      if (len > OFS_PROTO) fb[OFS_PROTO] = 8'h01;
      if (len > OFS_ICMP_TYPE) fb[OFS_ICMP_TYPE] = 8'h08;
    end
    if (kind == FR_BROKEN && len > bad_pos) fb[bad_pos] = fb[bad_pos] ^ bad_mask;
    foreach (fb[i]) begin
      // slot only matters on the final byte; scramble it elsewhere
      tag = (i == len - 1) ? slot : 6'($urandom_range(0, 63));
      push_byte(fb[i], i == len - 1, tag);
    end
    frames_sent++;
  endtask

  task automatic random_frame(input int len_max);
    int len;
    int pick;
    int bad;
    frame_kind_t kind;
    logic [5:0] slot;
    pick = $urandom_range(0, 99);
    if (pick < 35) len = $urandom_range(1, 41);
    else if (pick < 85) len = $urandom_range(42, 44);
    else len = $urandom_range(45, 64);
    if (len > len_max) len = $urandom_range(1, len_max);
    pick = $urandom_range(0, 99);
    kind = (pick < 70) ? FR_ECHO : (pick < 85) ? FR_BROKEN : FR_NOISE;
    if ($urandom_range(0, 3) != 0) slot = hot_slots[$urandom_range(0, 3)];
    else slot = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 3))
      0: bad = OFS_ETYPE_HI;
      1: bad = OFS_ETYPE_LO;
      2: bad = OFS_PROTO;
      default: bad = OFS_ICMP_TYPE;
    endcase
    send_frame(len, kind, slot, bad, 8'($urandom_range(1, 255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // a trailing non-final byte may still be in the parser
    repeat (8) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall per transaction, plus one long hold on request.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end
      n = rx_steady ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] phase_limit [PHASES];
    int base_bytes;
    int base_frames;
    phase_limit = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd3, 32'd0, 32'd0};
    phase_limit[4] = $urandom_range(0, 12);
    phase_limit[5] = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset threshold
    push_byte(8'hFF, 1'b1, 6'd63);
    send_frame(41, FR_ECHO, 6'd0, 0, 8'h00);
    send_frame(42, FR_ECHO, 6'd0, 0, 8'h00);
    for (int i = 0; i < 13; i++) push_byte(8'hFF, i == 12, 6'd63);
    send_frame(35, FR_ECHO, 6'd0, 0, 8'h00);
    send_frame(64, FR_ECHO, 6'd0, 0, 8'h00);
    send_frame(42, FR_BROKEN, 6'd0, OFS_ETYPE_HI, 8'h08);
    send_frame(42, FR_BROKEN, 6'd0, OFS_ETYPE_LO, 8'h01);
    send_frame(42, FR_BROKEN, 6'd0, OFS_PROTO, 8'h10);
    send_frame(42, FR_BROKEN, 6'd0, OFS_ICMP_TYPE, 8'h08);
    send_frame(42, FR_ECHO, 6'd63, 0, 8'h00);
    send_frame(43, FR_NOISE, 6'd21, 0, 8'h00);
    drain();

    // back up the result queue with tiny frames until the input stalls
    tx_steady = 1'b1;
    long_hold_req = 1'b1;
    repeat (120) random_frame(3);
    drain();

    base_bytes = bytes_sent;
    base_frames = frames_sent;
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(phase_limit[p]);
      tx_steady = (p == 1) || ($urandom_range(0, 3) == 0);
      rx_steady = (p == 1) || ($urandom_range(0, 3) == 0);
      while (bytes_sent - base_bytes < BYTE_TARGET * (p + 1) / PHASES ||
             frames_sent - base_frames < FRAME_TARGET * (p + 1) / PHASES)
        random_frame(64);
      drain();
    end

    repeat (12) @(negedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
